// File: design/frame_pixels_to_rgb888_macros.svh
// Assertion macros shared by the frame pixel converter modules
`ifndef FRAME_PIXELS_TO_RGB888_MACROS_SVH
`define FRAME_PIXELS_TO_RGB888_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FPR_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define FPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fpr_pkg.sv
// Types, codes and expansion tables of the frame pixel converter
package fpr_pkg;

  localparam int FORMAT_W = 2;
  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 13;
  localparam int PITCH_W  = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_INDEX_W = 2;

  localparam logic [FORMAT_W-1:0] FMT_RGB565   = 2'd0;
  localparam logic [FORMAT_W-1:0] FMT_RGB1555  = 2'd1;
  localparam logic [FORMAT_W-1:0] FMT_XRGB8888 = 2'd2;
  localparam logic [FORMAT_W-1:0] FMT_UNKNOWN  = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_FORMAT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PITCH  = 2'd3;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd320;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd240;
  localparam logic [PITCH_W-1:0]  PITCH_RESET  = 15'd640;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_565  = 2'd0,
    KIND_1555 = 2'd1,
    KIND_8888 = 2'd2,
    KIND_BAD  = 2'd3
  } pix_kind_t;

  // One classified pixel on its way from front to back
  typedef struct packed {
    pix_kind_t   kind;
    logic [23:0] data;
    logic        row_end;
    logic        frame_end;
  } pix_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef logic [31:0][7:0] exp5_t;
  typedef logic [63:0][7:0] exp6_t;

  function automatic exp5_t build_exp5();
    exp5_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255) / 31);
    end
    return t;
  endfunction

  function automatic exp6_t build_exp6();
    exp6_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * 255) / 63);
    end
    return t;
  endfunction

  // v*255/31 and v*255/63, rounded down, built at elaboration
  localparam exp5_t EXP5 = build_exp5();
  localparam exp6_t EXP6 = build_exp6();

endpackage

// File: design/fpr_byte_if.sv
// Byte channel carrying the source frame buffer
interface fpr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// File: design/fpr_rgb_if.sv
// Pixel channel carrying one RGB888 result per pixel
interface fpr_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       row_end;
  logic       frame_end;
  logic       bad_format;

  modport source (output valid, output red, output green, output blue,
                  output row_end, output frame_end, output bad_format, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input row_end, input frame_end, input bad_format, output ready);
endinterface

// File: design/fpr_front.sv
// Front end: registers, byte assembly, row and frame position tracking
module fpr_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_enable,
  input  logic [fpr_pkg::CFG_INDEX_W-1:0]     reg_index,
  input  logic [fpr_pkg::CFG_DATA_W-1:0]      write_data,
  fpr_byte_if.sink                            pixel_in,
  input  fpr_pkg::q_status_t                  q_stat,
  output logic                                push,
  output fpr_pkg::pix_rec_t                   push_rec
);

  localparam int CAP  = 4 * MAX_WIDTH;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PW   = $clog2(CAP + 1);
  localparam int RBW  = $clog2(CAP);
  localparam int PXW  = (PW > fpr_pkg::PITCH_W) ? PW : fpr_pkg::PITCH_W;
  localparam int WXW  = (WW > fpr_pkg::WIDTH_W) ? WW + 1 : fpr_pkg::WIDTH_W + 1;
  localparam int HXW  = (HW > fpr_pkg::HEIGHT_W) ? HW + 1 : fpr_pkg::HEIGHT_W + 1;

  logic [fpr_pkg::FORMAT_W-1:0] pixel_format;
  logic [fpr_pkg::WIDTH_W-1:0]  frame_width;
  logic [fpr_pkg::HEIGHT_W-1:0] frame_height;
  logic [fpr_pkg::PITCH_W-1:0]  row_pitch;

  logic [23:0]    pixel_bytes;
  logic [1:0]     byte_in_pixel;
  logic [CW-1:0]  column_count;
  logic [RW-1:0]  row_count;
  logic [RBW-1:0] row_byte_count;

  logic           accept;
  logic           fmt_bad;
  logic           four;
  logic [WW-1:0]  w;
  logic [HW-1:0]  h;
  logic [PW-1:0]  row_bytes;
  logic [PXW-1:0] pitch_raw;
  logic [PW-1:0]  pitch;
  logic           last_row_byte;
  logic           padding;
  logic           pixel_last;
  logic           col_last;
  logic           row_last;

  assign pixel_in.ready = !q_stat.full;
  assign accept = pixel_in.valid && pixel_in.ready;

  always_comb begin
    fmt_bad = (pixel_format == fpr_pkg::FMT_UNKNOWN);
    four    = (pixel_format == fpr_pkg::FMT_XRGB8888);

    // Clamp width and height into 1..max
    if (frame_width == '0) begin
      w = WW'(1);
    end else if (WXW'(frame_width) > WXW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h = HW'(1);
    end else if (HXW'(frame_height) > HXW'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(frame_height);
    end

    row_bytes = four ? (PW'(w) << 2) : (PW'(w) << 1);

    // Short pitch grows to the row, long pitch is capped
    pitch_raw = (PXW'(row_pitch) < PXW'(row_bytes)) ? PXW'(row_bytes) : PXW'(row_pitch);
    pitch     = (pitch_raw > PXW'(CAP)) ? PW'(CAP) : PW'(pitch_raw);

    last_row_byte = ((PW + 1)'(row_byte_count) + (PW + 1)'(1)) >= (PW + 1)'(pitch);
    padding       = PW'(row_byte_count) >= row_bytes;
    pixel_last    = four ? (byte_in_pixel == 2'd3) : (byte_in_pixel != 2'd0);
    col_last      = ((WW + 1)'(column_count) + (WW + 1)'(1)) >= (WW + 1)'(w);
    row_last      = ((HW + 1)'(row_count) + (HW + 1)'(1)) >= (HW + 1)'(h);

    push = accept && (fmt_bad || (!padding && pixel_last));

    push_rec.row_end   = 1'b0;
    push_rec.frame_end = 1'b0;
    push_rec.data      = '0;
    case (pixel_format)
      fpr_pkg::FMT_RGB565: begin
        push_rec.kind = fpr_pkg::KIND_565;
      end
      fpr_pkg::FMT_RGB1555: begin
        push_rec.kind = fpr_pkg::KIND_1555;
      end
      fpr_pkg::FMT_XRGB8888: begin
        push_rec.kind = fpr_pkg::KIND_8888;
      end
      default: begin
        push_rec.kind = fpr_pkg::KIND_BAD;
      end
    endcase
    if (!fmt_bad) begin
      push_rec.data      = four ? pixel_bytes : {8'h00, pixel_in.data_byte, pixel_bytes[7:0]};
      push_rec.row_end   = col_last;
      push_rec.frame_end = col_last && row_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format   <= fpr_pkg::FMT_RGB565;
      frame_width    <= fpr_pkg::WIDTH_RESET;
      frame_height   <= fpr_pkg::HEIGHT_RESET;
      row_pitch      <= fpr_pkg::PITCH_RESET;
      pixel_bytes    <= '0;
      byte_in_pixel  <= '0;
      column_count   <= '0;
      row_count      <= '0;
      row_byte_count <= '0;
    end else if (write_enable) begin
      case (reg_index)
        fpr_pkg::REG_FORMAT: pixel_format <= write_data[fpr_pkg::FORMAT_W-1:0];
        fpr_pkg::REG_WIDTH:  frame_width  <= write_data[fpr_pkg::WIDTH_W-1:0];
        fpr_pkg::REG_HEIGHT: frame_height <= write_data[fpr_pkg::HEIGHT_W-1:0];
        fpr_pkg::REG_PITCH:  row_pitch    <= write_data[fpr_pkg::PITCH_W-1:0];
        default: row_pitch <= row_pitch;
      endcase
      // Restart the frame on any register write
      pixel_bytes    <= '0;
      byte_in_pixel  <= '0;
      column_count   <= '0;
      row_count      <= '0;
      row_byte_count <= '0;
    end else if (accept && !fmt_bad) begin
      if (padding || pixel_last) begin
        if (!padding) begin
          pixel_bytes   <= '0;
          byte_in_pixel <= '0;
          column_count  <= col_last ? '0 : column_count + CW'(1);
        end
        if (last_row_byte) begin
          row_byte_count <= '0;
          row_count      <= row_last ? '0 : row_count + RW'(1);
        end else begin
          row_byte_count <= row_byte_count + RBW'(1);
        end
      end else begin
        case (byte_in_pixel)
          2'd0:    pixel_bytes[7:0]   <= pixel_in.data_byte;
          2'd1:    pixel_bytes[15:8]  <= pixel_in.data_byte;
          default: pixel_bytes[23:16] <= pixel_in.data_byte;
        endcase
        byte_in_pixel  <= byte_in_pixel + 2'd1;
        row_byte_count <= row_byte_count + RBW'(1);
      end
    end
  end

endmodule

// File: design/fpr_queue.sv
// Short queue of classified pixels between front and back
`include "frame_pixels_to_rgb888_macros.svh"

module fpr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fpr_pkg::pix_rec_t   push_rec,
  input  logic                pop,
  output fpr_pkg::pix_rec_t   pop_rec,
  output fpr_pkg::q_status_t  q_stat
);

  fpr_pkg::pix_rec_t entries [fpr_pkg::QUEUE_DEPTH];

  logic [fpr_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [fpr_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [fpr_pkg::QUEUE_AW:0]   count;

  assign q_stat.full  = (count == (fpr_pkg::QUEUE_AW + 1)'(fpr_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_rec      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + fpr_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + fpr_pkg::QUEUE_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (fpr_pkg::QUEUE_AW + 1)'(1);
        2'b01:   count <= count - (fpr_pkg::QUEUE_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  `FPR_ASSERT(a_no_push_full, clk, rst, push && q_stat.full, 1'b0, "pixel queue overrun")
  `FPR_ASSERT(a_no_pop_empty, clk, rst, pop && q_stat.empty, 1'b0, "pixel queue underrun")

endmodule

// File: design/fpr_back.sv
// Back end: component expansion and the registered result stage
`include "frame_pixels_to_rgb888_macros.svh"

module fpr_back (
  input  logic                clk,
  input  logic                rst,
  input  fpr_pkg::pix_rec_t   pop_rec,
  input  fpr_pkg::q_status_t  q_stat,
  output logic                pop,
  fpr_rgb_if.source           rgb_out
);

  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;
  logic       bad_next;

  // Take the next pixel whenever the result register is free or being drained
  assign pop = !q_stat.empty && (!rgb_out.valid || rgb_out.ready);

  always_comb begin
    bad_next = 1'b0;
    case (pop_rec.kind)
      fpr_pkg::KIND_565: begin
        red_next   = fpr_pkg::EXP5[pop_rec.data[15:11]];
        green_next = fpr_pkg::EXP6[pop_rec.data[10:5]];
        blue_next  = fpr_pkg::EXP5[pop_rec.data[4:0]];
      end
      fpr_pkg::KIND_1555: begin
        red_next   = fpr_pkg::EXP5[pop_rec.data[14:10]];
        green_next = fpr_pkg::EXP5[pop_rec.data[9:5]];
        blue_next  = fpr_pkg::EXP5[pop_rec.data[4:0]];
      end
      fpr_pkg::KIND_8888: begin
        red_next   = pop_rec.data[23:16];
        green_next = pop_rec.data[15:8];
        blue_next  = pop_rec.data[7:0];
      end
      default: begin
        red_next   = 8'h00;
        green_next = 8'h00;
        blue_next  = 8'h00;
        bad_next   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_out.valid <= 1'b0;
    end else if (pop) begin
      rgb_out.valid <= 1'b1;
    end else if (rgb_out.ready) begin
      rgb_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rgb_out.red        <= red_next;
      rgb_out.green      <= green_next;
      rgb_out.blue       <= blue_next;
      rgb_out.row_end    <= pop_rec.row_end;
      rgb_out.frame_end  <= pop_rec.frame_end;
      rgb_out.bad_format <= bad_next;
    end
  end

  `FPR_ASSERT(a_bad_is_blank, clk, rst, rgb_out.valid && rgb_out.bad_format,
    rgb_out.red == 8'h00 && rgb_out.green == 8'h00 && rgb_out.blue == 8'h00 &&
    !rgb_out.row_end && !rgb_out.frame_end, "bad format result not blank")
  `FPR_ASSERT(a_frame_end_row_end, clk, rst, rgb_out.valid && rgb_out.frame_end,
    rgb_out.row_end, "frame end without row end")
  `FPR_ASSERT_NEXT(a_pop_fills, clk, rst, pop, rgb_out.valid, "popped pixel not presented")

endmodule

// File: design/frame_pixels_to_rgb888.sv
// Top level of the frame buffer byte stream to RGB888 pixel converter
//
// Use:
//   pixel_in  - byte channel (valid/ready/data_byte) carrying the frame buffer
//               in memory order; a transaction moves one byte.
//   rgb_out   - pixel channel carrying red/green/blue plus row_end, frame_end
//               and bad_format; one transaction per completed pixel or per bad-format byte.
//   write_enable/reg_index/write_data - register writes (format, width,
//               height, pitch); any write restarts the frame. Write only while
//               the block is idle.
// Throughput: one byte per cycle while the queue is not full; bytes are taken while earlier
//   pixels still sit in the queue or the output register.
// Path: the edge that accepts a pixel's last byte writes the pixel into the
//   queue; it then loads into the result register once that register is free
//   or being drained, and is presented on rgb_out from there.
// Reset: registers return to RGB565, 320 x 240, pitch 640; position counters,
//   queue and output valid clear.
// Receiver stall: the result register holds; the four-entry queue fills, and
//   once it is full pixel_in.ready drops until the receiver drains it.
module frame_pixels_to_rgb888 #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_enable,
  input  logic [fpr_pkg::CFG_INDEX_W-1:0] reg_index,
  input  logic [fpr_pkg::CFG_DATA_W-1:0]  write_data,
  fpr_byte_if.sink                        pixel_in,
  fpr_rgb_if.source                       rgb_out
);

  // Front to queue, queue to back
  logic               push;
  logic               pop;
  fpr_pkg::pix_rec_t  push_rec;
  fpr_pkg::pix_rec_t  pop_rec;
  fpr_pkg::q_status_t q_stat;

  // Classify bytes, assemble pixels and track row and frame position
  fpr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .pixel_in     (pixel_in),
    .q_stat       (q_stat),
    .push         (push),
    .push_rec     (push_rec)
  );

  // Decouple the two sides so each can stall on its own
  fpr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .q_stat   (q_stat)
  );

  // Expand components and hold the result for the receiver
  fpr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .pop_rec (pop_rec),
    .q_stat  (q_stat),
    .pop     (pop),
    .rgb_out (rgb_out)
  );

endmodule
